// ===== rtl/core/hotp_pkg.sv =====
// Package for the HOTP code matcher: payload word types, SHA-1 constants and
// round helper functions. Used by every module in rtl/core.
package hotp_pkg;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_middle;
        logic [31:0] key_low;
        logic [63:0] moving_counter;
    } in_word_t;

    typedef struct packed {
        logic [19:0] otp_code;
        logic        is_match;
    } out_word_t;

    typedef logic [4:0][31:0]  state_t;
    typedef logic [15:0][31:0] sched_t;

    localparam int unsigned ROUNDS = 80;
    localparam logic [31:0] CODE_MODULUS = 32'd1000000;
    localparam logic [7:0]  INNER_PAD = 8'h36;
    localparam logic [7:0]  OUTER_PAD = 8'h5c;
    localparam logic        REG_TARGET = 1'b0;

    localparam state_t SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        begin
            rotl = (x << n) | (x >> (32 - n));
        end
    endfunction

    // One SHA-1 round; s[0] is a, s[4] is e; w is the oldest schedule word.
    function automatic state_t sha1_round(input state_t s, input logic [31:0] w,
                                          input int unsigned t);
        logic [31:0] f;
        logic [31:0] k;
        state_t r;
        begin
            if (t < 20) begin
                f = (s[1] & s[2]) | (~s[1] & s[3]);
                k = 32'h5A827999;
            end
            else if (t < 40) begin
                f = s[1] ^ s[2] ^ s[3];
                k = 32'h6ED9EBA1;
            end
            else if (t < 60) begin
                f = (s[1] & s[2]) | (s[1] & s[3]) | (s[2] & s[3]);
                k = 32'h8F1BBCDC;
            end
            else begin
                f = s[1] ^ s[2] ^ s[3];
                k = 32'hCA62C1D6;
            end
            r[0] = rotl(s[0], 5) + f + s[4] + k + w;
            r[1] = s[0];
            r[2] = rotl(s[1], 30);
            r[3] = s[2];
            r[4] = s[3];
            sha1_round = r;
        end
    endfunction

    // Shift the 16-word schedule window by one word.
    function automatic sched_t sched_next(input sched_t w);
        sched_t r;
        begin
            for (int i = 0; i < 15; i++) begin
                r[i] = w[i + 1];
            end
            r[15] = rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
            sched_next = r;
        end
    endfunction

endpackage

// ===== rtl/core/hotp_sha1_block.sv =====
// One SHA-1 compression pipeline: input stage, one round per register
// stage (80 stages), a final chaining add stage. Depends on hotp_pkg.
module hotp_sha1_block
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  hotp_pkg::state_t in_chain,
    input  hotp_pkg::sched_t in_block,
    output logic            out_valid,
    output hotp_pkg::state_t out_chain
);
    import hotp_pkg::*;

    logic   [ROUNDS:0] valid_reg;
    state_t            work_reg  [ROUNDS+1];
    state_t            chain_reg [ROUNDS+1];
    sched_t            sched_reg [ROUNDS+1];
    state_t            sum_reg;
    logic              sum_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg     <= '0;
            sum_valid_reg <= 1'b0;
        end
        else begin
            valid_reg     <= {valid_reg[ROUNDS-1:0], in_valid};
            sum_valid_reg <= valid_reg[ROUNDS];
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg[0]  <= in_chain;
        chain_reg[0] <= in_chain;
        sched_reg[0] <= in_block;
        for (int t = 0; t < ROUNDS; t++) begin
            work_reg[t+1]  <= sha1_round(work_reg[t], sched_reg[t][0], t);
            chain_reg[t+1] <= chain_reg[t];
            sched_reg[t+1] <= sched_next(sched_reg[t]);
        end
        for (int i = 0; i < 5; i++) begin
            sum_reg[i] <= chain_reg[ROUNDS][i] + work_reg[ROUNDS][i];
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_chain = sum_reg;

endmodule

// ===== rtl/core/hotp_truncate.sv =====
// Dynamic truncation and reduction modulo one million over four stages,
// the last of which also compares with the target code. Depends on hotp_pkg.
module hotp_truncate
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  hotp_pkg::state_t    in_digest,
    input  logic [19:0]        target_code,
    output logic               out_valid,
    output hotp_pkg::out_word_t out_word
);
    import hotp_pkg::*;

    logic [159:0] flat;
    logic [30:0]  word_reg;
    logic [31:0]  rem_reg;
    logic [31:0]  rem_next;
    logic [19:0]  code_reg;
    logic [3:0]   valid_reg;
    logic [3:0]   off;
    logic [7:0]   match_pos;
    logic         match_reg;

    always_comb
    begin
        flat = {in_digest[0], in_digest[1], in_digest[2], in_digest[3], in_digest[4]};
        off  = flat[3:0];
        match_pos = 8'd158 - {1'b0, off, 3'b000};
    end

    // Quotient estimate: word * floor(2^40/1e6) >> 40 is within two of the true one.
    logic [31:0] quot_reg;
    logic [30:0] word2_reg;
    logic [51:0] prod;
    assign prod = 52'(word_reg) * 52'd1099511;

    always_comb
    begin
        rem_next = rem_reg;
        if (rem_next >= CODE_MODULUS) begin
            rem_next = rem_next - CODE_MODULUS;
        end
        if (rem_next >= CODE_MODULUS) begin
            rem_next = rem_next - CODE_MODULUS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= flat[match_pos -: 31];
        quot_reg  <= 32'(prod >> 40);
        word2_reg <= word_reg;
        rem_reg   <= 32'(word2_reg) - 32'(quot_reg * CODE_MODULUS);
        code_reg  <= rem_next[19:0];
        match_reg <= (rem_next[19:0] == target_code);
    end

    assign out_valid         = valid_reg[3];
    assign out_word.otp_code = code_reg;
    assign out_word.is_match = match_reg;

endmodule

// ===== rtl/core/hotp_sha1_code_match.sv =====
// Top level of the HOTP code matcher: APB target register, four SHA-1
// compression pipelines and the truncation stage. Depends on hotp_pkg.

// The block accepts one word in every cycle and never raises busy. Each result
// appears with done high for one cycle, in input order, after passing through
// the four chained SHA-1 compressions of 82 register stages each (input, 80
// rounds, chaining add) and the four truncation stages, the first stage being
// loaded by the accepting edge itself. Results cannot be held off.
module hotp_sha1_code_match
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  hotp_pkg::in_word_t  in_word,
    output logic                done,
    output hotp_pkg::out_word_t out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import hotp_pkg::*;

    logic [19:0] target_reg;
    logic        v0, v1, v2, v3;
    state_t      h0, h1, h2, h3;
    sched_t      ib1, ib2, ob1, ob2;
    logic [159:0] key;
    logic [511:0] kblk;

    // Payload of a word travels alongside the first pipeline (counter) and the first two (outer key).
    logic [63:0] ctr_reg [82];
    logic [511:0] okey_reg [164];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TARGET) ? {12'd0, target_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            target_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_TARGET) begin
            target_reg <= pwdata[19:0];
        end
    end

    assign key  = {in_word.key_high, in_word.key_middle, in_word.key_low};
    assign kblk = {key, 352'd0};

    always_comb
    begin
        for (int i = 0; i < 64; i++) begin
            ib1[i/4][31 - 8*(i%4) -: 8] = kblk[511 - 8*i -: 8] ^ INNER_PAD;
        end
        ib2 = {32'd576, 32'd0, 352'd0, 32'h80000000,
               ctr_reg[81][31:0], ctr_reg[81][63:32]};
        for (int i = 0; i < 16; i++) begin
            ob1[i] = okey_reg[163][511 - 32*i -: 32];
        end
        ob2 = {32'd672, 32'd0, 256'd0, 32'h80000000,
               h1[4], h1[3], h1[2], h1[1], h1[0]};
    end

    always_ff @(posedge clk)
    begin
        ctr_reg[0] <= in_word.moving_counter;
        for (int i = 1; i < 82; i++) begin
            ctr_reg[i] <= ctr_reg[i-1];
        end
        for (int i = 0; i < 64; i++) begin
            okey_reg[0][511 - 8*i -: 8] <= kblk[511 - 8*i -: 8] ^ OUTER_PAD;
        end
        for (int i = 1; i < 164; i++) begin
            okey_reg[i] <= okey_reg[i-1];
        end
    end

    hotp_sha1_block u_inner1 (.clk(clk), .rst_n(rst_n), .in_valid(start),
        .in_chain(SHA1_IV), .in_block(ib1), .out_valid(v0), .out_chain(h0));
    hotp_sha1_block u_inner2 (.clk(clk), .rst_n(rst_n), .in_valid(v0),
        .in_chain(h0), .in_block(ib2), .out_valid(v1), .out_chain(h1));
    hotp_sha1_block u_outer1 (.clk(clk), .rst_n(rst_n), .in_valid(v1),
        .in_chain(SHA1_IV), .in_block(ob1), .out_valid(v2), .out_chain(h2));

    // The outer second block takes the inner digest when u_outer1 finishes, so ob2 waits in the ob2_reg delay line.
    sched_t        ob2_reg [82];
    always_ff @(posedge clk)
    begin
        ob2_reg[0] <= ob2;
        for (int i = 1; i < 82; i++) begin
            ob2_reg[i] <= ob2_reg[i-1];
        end
    end

    hotp_sha1_block u_outer2 (.clk(clk), .rst_n(rst_n), .in_valid(v2),
        .in_chain(h2), .in_block(ob2_reg[81]), .out_valid(v3), .out_chain(h3));

    hotp_truncate u_trunc (.clk(clk), .rst_n(rst_n), .in_valid(v3), .in_digest(h3),
        .target_code(target_reg), .out_valid(done), .out_word(out_word));

endmodule
